/* rtl/clm_pkg.sv */
// Package for the circular linked list manager: item types, control codes and the
// microprogram that sequences every list operation. Depends on nothing.
package clm_pkg;

	localparam int NODE_COUNT = 64;
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int CNT_W = $clog2(NODE_COUNT + 1);

	typedef enum logic [1:0] {
		KIND_PUSH_BACK  = 2'd0,
		KIND_PUSH_FRONT = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_REMOVE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE       = 2'd0,
		STATUS_EMPTY      = 2'd1,
		STATUS_NOT_LINKED = 2'd2,
		STATUS_LINKED     = 2'd3
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [NODE_W-1:0]  node;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0]  popped_node;
		status_t            status;
		logic [CNT_W-1:0]   count;
	} result_t;

	// Microprogram addresses.
	typedef enum logic [3:0] {
		S_IDLE        = 4'd0,
		S_PUSH_CHK    = 4'd1,
		S_PUSH_EMPTY  = 4'd2,
		S_PUSH_LINK   = 4'd3,
		S_PUSH_FIRST  = 4'd4,
		S_PUSH_REJ    = 4'd5,
		S_POP_CHK     = 4'd6,
		S_REM_CHK     = 4'd7,
		S_UNLINK      = 4'd8,
		S_UNLINK_LAST = 4'd9,
		S_POP_EMPTY   = 4'd10,
		S_REM_REJ     = 4'd11
	} step_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_PUSH_REJ,
		COND_EMPTY,
		COND_NOT_LINKED,
		COND_SELF_LOOP
	} cond_t;

	// Next-link memory write: which entry gets which value.
	typedef enum logic [2:0] {
		NW_NONE,
		NW_SELF,
		NW_NODE_TO_HEAD,
		NW_TAIL_TO_NODE,
		NW_PREV_TO_NEXT
	} nw_op_t;

	// Prev-link memory write.
	typedef enum logic [2:0] {
		PW_NONE,
		PW_SELF,
		PW_NODE_TO_TAIL,
		PW_HEAD_TO_NODE,
		PW_NEXT_TO_PREV
	} pw_op_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_ONE,
		CNT_INC,
		CNT_DEC,
		CNT_ZERO
	} cnt_op_t;

	typedef enum logic [1:0] {
		HD_HOLD,
		HD_NODE,
		HD_NODE_IF_FRONT,
		HD_NEXT_IF_HEAD
	} hd_op_t;

	typedef enum logic [1:0] {
		MK_HOLD,
		MK_SET,
		MK_CLR
	} mk_op_t;

	typedef enum logic [1:0] {
		SS_DONE,
		SS_EMPTY,
		SS_NOT_LINKED,
		SS_PUSH_REJ
	} st_sel_t;

	typedef struct packed {
		logic    wait_start;
		cond_t   cond;
		step_t   jump;
		step_t   nxt;
		nw_op_t  nw;
		pw_op_t  pw;
		cnt_op_t cnt;
		hd_op_t  hd;
		mk_op_t  mk;
		logic    done;
		st_sel_t st;
	} uword_t;

	// Control from the sequencer to the datapath for the current cycle.
	typedef struct packed {
		logic    accept;
		nw_op_t  nw;
		pw_op_t  pw;
		cnt_op_t cnt;
		hd_op_t  hd;
		mk_op_t  mk;
		logic    done;
		st_sel_t st;
	} ctl_t;

	// Branch conditions from the datapath back to the sequencer.
	typedef struct packed {
		logic push_rej;
		logic empty;
		logic not_linked;
		logic self_loop;
	} flags_t;

	localparam uword_t UW_NOP = '{
		wait_start: 1'b0, cond: COND_NONE, jump: S_IDLE, nxt: S_IDLE,
		nw: NW_NONE, pw: PW_NONE, cnt: CNT_HOLD, hd: HD_HOLD, mk: MK_HOLD,
		done: 1'b0, st: SS_DONE
	};

	// Entry point of the routine for each operation kind.
	function automatic step_t kind_entry(input kind_t kind);
		step_t s;
		unique case (kind)
			KIND_PUSH_BACK, KIND_PUSH_FRONT: s = S_PUSH_CHK;
			KIND_POP_FRONT:                  s = S_POP_CHK;
			KIND_REMOVE:                     s = S_REM_CHK;
			default:                         s = S_IDLE;
		endcase
		return s;
	endfunction

	// The microprogram. When a step's condition holds it jumps and does nothing
	// else; otherwise it performs its actions and moves to its next step.
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		w = UW_NOP;
		unique case (step)
			S_IDLE: begin
				w.wait_start = 1'b1;
			end
			S_PUSH_CHK: begin
				w.cond = COND_PUSH_REJ;
				w.jump = S_PUSH_REJ;
				w.nxt  = S_PUSH_EMPTY;
			end
			S_PUSH_EMPTY: begin
				w.cond = COND_EMPTY;
				w.jump = S_PUSH_FIRST;
				w.nxt  = S_PUSH_LINK;
				w.nw   = NW_NODE_TO_HEAD;
				w.pw   = PW_NODE_TO_TAIL;
			end
			S_PUSH_LINK: begin
				w.nw   = NW_TAIL_TO_NODE;
				w.pw   = PW_HEAD_TO_NODE;
				w.cnt  = CNT_INC;
				w.hd   = HD_NODE_IF_FRONT;
				w.mk   = MK_SET;
				w.done = 1'b1;
			end
			S_PUSH_FIRST: begin
				w.nw   = NW_SELF;
				w.pw   = PW_SELF;
				w.cnt  = CNT_ONE;
				w.hd   = HD_NODE;
				w.mk   = MK_SET;
				w.done = 1'b1;
			end
			S_PUSH_REJ: begin
				w.done = 1'b1;
				w.st   = SS_PUSH_REJ;
			end
			S_POP_CHK: begin
				w.cond = COND_EMPTY;
				w.jump = S_POP_EMPTY;
				w.nxt  = S_UNLINK;
			end
			S_REM_CHK: begin
				w.cond = COND_NOT_LINKED;
				w.jump = S_REM_REJ;
				w.nxt  = S_UNLINK;
			end
			S_UNLINK: begin
				w.cond = COND_SELF_LOOP;
				w.jump = S_UNLINK_LAST;
				w.nw   = NW_PREV_TO_NEXT;
				w.pw   = PW_NEXT_TO_PREV;
				w.cnt  = CNT_DEC;
				w.hd   = HD_NEXT_IF_HEAD;
				w.mk   = MK_CLR;
				w.done = 1'b1;
			end
			S_UNLINK_LAST: begin
				w.cnt  = CNT_ZERO;
				w.mk   = MK_CLR;
				w.done = 1'b1;
			end
			S_POP_EMPTY: begin
				w.done = 1'b1;
				w.st   = SS_EMPTY;
			end
			S_REM_REJ: begin
				w.done = 1'b1;
				w.st   = SS_NOT_LINKED;
			end
			default: begin
				w = UW_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/circular_linked_list_manager_unit.sv */
// Top level of the circular linked list manager: sequencer plus datapath.
// Depends on clm_pkg, clm_sequencer and clm_datapath.
//
// This block keeps one circular doubly linked list over a pool of NODE_COUNT node
// slots and runs one operation per transaction: push back, push front, pop front
// or remove a given node. A transaction is accepted at a rising edge where start
// is high and busy is low; busy then stays high while a small microprogram reads
// the node's links and rewrites the neighbors' links. Pops and removes that fail
// their check, and rejected pushes, run their check step and then a result step;
// an accepted push runs its check, its empty test and then a first-node or link
// step; a pop or remove that succeeds runs its check and its unlink step, plus a
// last-node step when it takes out the last node. The result appears on result
// with done high for exactly one cycle, the same cycle busy drops, so a new
// transaction can be started right then; none is taken while busy is high. The
// routines are split into steps since each link memory has a single write port
// and a push must update four links. The receiver cannot stall, so it must take
// every result in the cycle done is high. Every transaction yields exactly one
// result. The link memories need no clearing after reset; only the step counter,
// the per-node linked marks, the head, the count and the done strobe are reset.
module circular_linked_list_manager_unit
	import clm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	ctl_t   ctl;
	flags_t flags;

	// Step counter and control store.
	clm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (cmd.kind),
		.flags  (flags),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Link memories, marks, head, count and the result register.
	clm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.flags  (flags),
		.done   (done),
		.result (result)
	);

endmodule

/* rtl/clm_sequencer.sv */
// Microcode sequencer of the circular linked list manager: step counter, control
// store lookup and conditional jumps. Depends on clm_pkg.
module clm_sequencer
	import clm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  kind_t  kind,
	input  flags_t flags,
	output logic   busy,
	output ctl_t   ctl
);

	step_t  step_q;
	step_t  step_nxt;
	uword_t uw;
	logic   cond_hit;

	assign uw = ucode_rom(step_q);

	always_comb begin
		unique case (uw.cond)
			COND_NONE:       cond_hit = 1'b0;
			COND_PUSH_REJ:   cond_hit = flags.push_rej;
			COND_EMPTY:      cond_hit = flags.empty;
			COND_NOT_LINKED: cond_hit = flags.not_linked;
			COND_SELF_LOOP:  cond_hit = flags.self_loop;
			default:         cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		ctl.accept = uw.wait_start & start;
		ctl.nw     = NW_NONE;
		ctl.pw     = PW_NONE;
		ctl.cnt    = CNT_HOLD;
		ctl.hd     = HD_HOLD;
		ctl.mk     = MK_HOLD;
		ctl.done   = 1'b0;
		ctl.st     = uw.st;
		if (uw.wait_start) begin
			step_nxt = start ? kind_entry(kind) : S_IDLE;
		end else if (cond_hit) begin
			step_nxt = uw.jump;
		end else begin
			step_nxt = uw.nxt;
			ctl.nw   = uw.nw;
			ctl.pw   = uw.pw;
			ctl.cnt  = uw.cnt;
			ctl.hd   = uw.hd;
			ctl.mk   = uw.mk;
			ctl.done = uw.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign busy = (step_q != S_IDLE);

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> (step_q == S_IDLE))
		else $error("sequencer did not return to idle after a result");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> (step_q == S_IDLE) && !busy)
		else $error("transaction accepted outside the idle step");

	a_no_action_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_IDLE) |-> !ctl.done && (ctl.nw == NW_NONE) && (ctl.pw == PW_NONE))
		else $error("datapath action issued from the idle step");

endmodule

/* rtl/clm_datapath.sv */
// Datapath of the circular linked list manager: link memories, linked marks, head,
// count and the result register. Depends on clm_pkg.
module clm_datapath
	import clm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  ctl_t    ctl,
	output flags_t  flags,
	output logic    done,
	output result_t result
);

	logic [NODE_W-1:0] next_mem [NODE_COUNT];
	logic [NODE_W-1:0] prev_mem [NODE_COUNT];

	logic [NODE_COUNT-1:0] mark_q;
	logic [NODE_W-1:0]     head_q;
	logic [CNT_W-1:0]      count_q;
	kind_t                 kind_q;
	logic [NODE_W-1:0]     node_q;
	logic [NODE_W-1:0]     rd_next_q;
	logic [NODE_W-1:0]     rd_prev_q;
	result_t               result_q;
	logic                  done_q;

	logic [NODE_W-1:0] raddr;
	logic              in_pool;
	logic              nw_en, pw_en;
	logic [NODE_W-1:0] nw_addr, nw_data, pw_addr, pw_data;
	logic [CNT_W-1:0]  count_nxt;
	status_t           status;

	// Pops and pushes read around the head; a remove reads the named node.
	assign raddr = (cmd.kind == KIND_REMOVE) ? cmd.node : head_q;

	assign in_pool = (CNT_W'(node_q) < CNT_W'(NODE_COUNT));

	assign flags.push_rej   = !in_pool || mark_q[node_q];
	assign flags.empty      = (count_q == '0);
	assign flags.not_linked = !in_pool || !mark_q[node_q];
	assign flags.self_loop  = (rd_next_q == node_q) || (rd_prev_q == node_q);

	always_comb begin
		nw_en   = 1'b0;
		nw_addr = node_q;
		nw_data = node_q;
		unique case (ctl.nw)
			NW_NONE: begin
			end
			NW_SELF: begin
				nw_en = 1'b1;
			end
			NW_NODE_TO_HEAD: begin
				nw_en   = 1'b1;
				nw_data = head_q;
			end
			NW_TAIL_TO_NODE: begin
				nw_en   = 1'b1;
				nw_addr = rd_prev_q;
			end
			NW_PREV_TO_NEXT: begin
				nw_en   = 1'b1;
				nw_addr = rd_prev_q;
				nw_data = rd_next_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pw_en   = 1'b0;
		pw_addr = node_q;
		pw_data = node_q;
		unique case (ctl.pw)
			PW_NONE: begin
			end
			PW_SELF: begin
				pw_en = 1'b1;
			end
			PW_NODE_TO_TAIL: begin
				pw_en   = 1'b1;
				pw_data = rd_prev_q;
			end
			PW_HEAD_TO_NODE: begin
				pw_en   = 1'b1;
				pw_addr = head_q;
			end
			PW_NEXT_TO_PREV: begin
				pw_en   = 1'b1;
				pw_addr = rd_next_q;
				pw_data = rd_prev_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nw_en) begin
			next_mem[nw_addr] <= nw_data;
		end
		if (pw_en) begin
			prev_mem[pw_addr] <= pw_data;
		end
		if (ctl.accept) begin
			rd_next_q <= next_mem[raddr];
			rd_prev_q <= prev_mem[raddr];
			kind_q    <= cmd.kind;
			node_q    <= (cmd.kind == KIND_POP_FRONT) ? head_q : cmd.node;
		end
	end

	always_comb begin
		unique case (ctl.cnt)
			CNT_HOLD: count_nxt = count_q;
			CNT_ONE:  count_nxt = CNT_W'(1);
			CNT_INC:  count_nxt = count_q + CNT_W'(1);
			CNT_DEC:  count_nxt = count_q - CNT_W'(1);
			CNT_ZERO: count_nxt = '0;
			default:  count_nxt = count_q;
		endcase
	end

	always_comb begin
		unique case (ctl.st)
			SS_DONE:       status = STATUS_DONE;
			SS_EMPTY:      status = STATUS_EMPTY;
			SS_NOT_LINKED: status = STATUS_NOT_LINKED;
			SS_PUSH_REJ:   status = in_pool ? STATUS_LINKED : STATUS_NOT_LINKED;
			default:       status = STATUS_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= ctl.done;
			unique case (ctl.mk)
				MK_HOLD: begin
				end
				MK_SET:  mark_q[node_q] <= 1'b1;
				MK_CLR:  mark_q[node_q] <= 1'b0;
				default: begin
				end
			endcase
			unique case (ctl.hd)
				HD_HOLD: begin
				end
				HD_NODE: head_q <= node_q;
				HD_NODE_IF_FRONT: begin
					if (kind_q == KIND_PUSH_FRONT) begin
						head_q <= node_q;
					end
				end
				HD_NEXT_IF_HEAD: begin
					if (node_q == head_q) begin
						head_q <= rd_next_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			result_q.popped_node <= (kind_q == KIND_POP_FRONT && status == STATUS_DONE)
				? node_q : '0;
			result_q.status      <= status;
			result_q.count       <= count_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_matches_marks: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(mark_q) == int'(count_q))
		else $error("linked marks disagree with the node count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= NODE_COUNT)
		else $error("node count above pool size");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for circular_linked_list_manager_unit.
// Drives push, pop and remove transactions and checks each result against a list predictor.
// Depends on clm_pkg and the circular_linked_list_manager_unit RTL.
`timescale 1ns / 100ps

module tb_top;
	import clm_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;

	circular_linked_list_manager_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Predicted list: links, membership marks, head and length.
	logic [NODE_W-1:0] list_next [NODE_COUNT];
	logic [NODE_W-1:0] list_prev [NODE_COUNT];
	bit                on_list   [NODE_COUNT];
	logic [NODE_W-1:0] list_head;
	int unsigned       list_len;

	// Stimulus-side view of the list as an ordered queue, used only to pick nodes.
	int unsigned       order_model [$];
	bit                order_on    [NODE_COUNT];

	cmd_t        pending_cmds     [$];
	result_t     expected_results [$];

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned error_count;
	int unsigned status_seen [4];
	int unsigned peak_len;
	int unsigned cycle_count;
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	logic        item_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Take a linked node out of the predicted list.
	function automatic void unlink_predicted(input logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] nx;
		logic [NODE_W-1:0] pv;
		nx = list_next[n];
		pv = list_prev[n];
		if (nx != n && pv != n) begin
			list_prev[nx] = pv;
			list_next[pv] = nx;
			if (list_len > 0)
				list_len--;
			if (n == list_head)
				list_head = nx;
		end else begin
			// The last node leaves; the head keeps its stale value.
			list_len = 0;
		end
		on_list[n] = 1'b0;
	endfunction

	// Apply one list operation to the predicted state and return its result.
	function automatic result_t apply_list_op(input cmd_t c);
		result_t           r;
		logic [NODE_W-1:0] n;
		logic [NODE_W-1:0] tail;
		r        = '0;
		r.status = STATUS_DONE;
		n        = c.node;
		case (c.kind)
			KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
				if (on_list[n]) begin
					r.status = STATUS_LINKED;
				end else begin
					if (list_len == 0) begin
						list_head    = n;
						list_next[n] = n;
						list_prev[n] = n;
						list_len     = 1;
					end else begin
						tail               = list_prev[list_head];
						list_prev[n]       = tail;
						list_next[n]       = list_head;
						list_next[tail]    = n;
						list_prev[list_head] = n;
						list_len++;
					end
					on_list[n] = 1'b1;
					if (c.kind == KIND_PUSH_FRONT)
						list_head = n;
				end
			end
			KIND_POP_FRONT: begin
				if (list_len == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.popped_node = list_head;
					unlink_predicted(list_head);
				end
			end
			default: begin
				if (!on_list[n])
					r.status = STATUS_NOT_LINKED;
				else
					unlink_predicted(n);
			end
		endcase
		r.count = list_len[CNT_W-1:0];
		return r;
	endfunction

	// Queue one transaction and track its effect on the ordered view of the list.
	task automatic add_cmd(input kind_t k, input logic [NODE_W-1:0] n);
		cmd_t c;
		int   pos;
		c.kind = k;
		c.node = n;
		pending_cmds.push_back(c);
		pos = -1;
		case (k)
			KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
				if (!order_on[n]) begin
					if (k == KIND_PUSH_FRONT)
						order_model.push_front(32'(n));
					else
						order_model.push_back(32'(n));
					order_on[n] = 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (order_model.size() > 0)
					order_on[order_model.pop_front()] = 1'b0;
			end
			default: begin
				if (order_on[n]) begin
					foreach (order_model[i])
						if (order_model[i] == n)
							pos = i;
					order_model.delete(pos);
					order_on[n] = 1'b0;
				end
			end
		endcase
	endtask

	// Driver: bursts of transactions separated by random gaps. A held start stays
	// high until the block takes the transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			item_taken = start && !busy;
			if (item_taken) begin
				expected_results.push_back(apply_list_op(cmd));
				items_sent++;
				if (list_len > peak_len)
					peak_len = list_len;
			end
			if (start && !item_taken) begin
				// Still waiting for the block to take the current transaction.
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				start <= 1'b1;
				cmd   <= pending_cmds.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done pulse carries one result, compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("Error at %0t: result with no transaction outstanding", $time);
			end else begin
				want = expected_results.pop_front();
				if (result.popped_node !== want.popped_node || result.status !== want.status
						|| result.count !== want.count) begin
					error_count++;
					if (error_count <= REPORT_MAX) begin
						$display("Mismatch at %0t: expected node %0d status %0d count %0d,",
							$time, want.popped_node, want.status, want.count);
						$display("    got node %0d status %0d count %0d",
							result.popped_node, result.status, result.count);
					end
				end
				status_seen[want.status]++;
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("** circular_linked_list_manager_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		bit                grow;
		int unsigned       seg_left;
		int unsigned       pick;
		kind_t             k;
		logic [NODE_W-1:0] n;

		grow     = 1'b0;
		seg_left = 0;
		for (int i = 0; i < NODE_COUNT; i++) begin
			on_list[i]   = 1'b0;
			order_on[i]  = 1'b0;
			list_next[i] = '0;
			list_prev[i] = '0;
		end
		list_head = '0;
		list_len  = 0;
		arst_n    = 1'b0;

		// Directed part: empty-list corners, extreme node indices, rejections,
		// and removal at the head, in the middle, at the tail and of the last node.
		add_cmd(KIND_POP_FRONT,  6'd0);
		add_cmd(KIND_REMOVE,     6'd0);
		add_cmd(KIND_PUSH_BACK,  6'd0);
		add_cmd(KIND_PUSH_BACK,  6'd0);
		add_cmd(KIND_PUSH_BACK,  6'd63);
		add_cmd(KIND_PUSH_FRONT, 6'd42);
		add_cmd(KIND_PUSH_FRONT, 6'd21);
		add_cmd(KIND_PUSH_FRONT, 6'd63);
		add_cmd(KIND_REMOVE,     6'd15);
		add_cmd(KIND_REMOVE,     6'd0);
		add_cmd(KIND_REMOVE,     6'd21);
		add_cmd(KIND_REMOVE,     6'd63);
		add_cmd(KIND_POP_FRONT,  6'd63);
		add_cmd(KIND_POP_FRONT,  6'd0);
		add_cmd(KIND_REMOVE,     6'd42);
		add_cmd(KIND_PUSH_FRONT, 6'd63);
		add_cmd(KIND_POP_FRONT,  6'd5);
		add_cmd(KIND_PUSH_BACK,  6'd7);
		add_cmd(KIND_REMOVE,     6'd7);
		add_cmd(KIND_PUSH_BACK,  6'd1);
		add_cmd(KIND_PUSH_BACK,  6'd2);
		add_cmd(KIND_PUSH_FRONT, 6'd3);
		add_cmd(KIND_REMOVE,     6'd2);
		add_cmd(KIND_POP_FRONT,  6'd0);
		add_cmd(KIND_POP_FRONT,  6'd0);

		// Random part: segments alternately fill the list toward full and drain it
		// toward empty with well-formed pushes, pops and removes; some items are noise.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (seg_left == 0) begin
				grow     = !grow;
				seg_left = $urandom_range(80, 260);
			end
			seg_left--;
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				k = kind_t'($urandom_range(0, 3));
				n = NODE_W'($urandom);
			end else begin
				pick = $urandom_range(0, 99);
				if ((grow && pick < 70) || (!grow && pick < 25)) begin
					k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
					n = NODE_W'($urandom);
					if (order_model.size() < NODE_COUNT)
						while (order_on[n])
							n = NODE_W'($urandom);
				end else if ($urandom_range(0, 1)) begin
					k = KIND_POP_FRONT;
					n = NODE_W'($urandom);
				end else begin
					k = KIND_REMOVE;
					if (order_model.size() > 0)
						n = NODE_W'(order_model[$urandom_range(0, order_model.size() - 1)]);
					else
						n = NODE_W'($urandom);
				end
			end
			add_cmd(k, n);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (expected_results.size() != 0)
			error_count++;
		$display("Ran %0d transactions and checked %0d results, peak list length %0d.",
			items_sent, results_seen, peak_len);
		$display("Statuses seen: %0d done, %0d empty pops, %0d not linked, %0d linked pushes.",
			status_seen[STATUS_DONE], status_seen[STATUS_EMPTY],
			status_seen[STATUS_NOT_LINKED], status_seen[STATUS_LINKED]);
		if (error_count == 0) begin
			$display("** circular_linked_list_manager_unit: PASSED **");
		end else begin
			$display("%0d errors", error_count);
			$display("** circular_linked_list_manager_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* circular_linked_list_manager_unit.f */
rtl/clm_pkg.sv
rtl/clm_sequencer.sv
rtl/clm_datapath.sv
rtl/circular_linked_list_manager_unit.sv
dv/tb_top.sv
